FILE: sv/accs_pkg.sv
// accs_pkg: shared constants, symbol codes and the bcd adjust helper
// for the capital-numeral amount block; depends on nothing
`default_nettype none

package accs_pkg;

    localparam int AMT_W      = 40;
    localparam int SYM_W      = 5;
    localparam int DIGITS     = 12;
    localparam int BCD_W      = 4 * DIGITS;
    localparam int CONV_STEPS = AMT_W;
    localparam int CNT_W      = $clog2(CONV_STEPS);

    localparam logic [AMT_W-1:0] AMT_MAX = 40'd999999999999;

    localparam logic [SYM_W-1:0] SYM_LING  = 5'd0;
    localparam logic [SYM_W-1:0] SYM_SHI   = 5'd10;
    localparam logic [SYM_W-1:0] SYM_WAN   = 5'd13;
    localparam logic [SYM_W-1:0] SYM_YI    = 5'd14;
    localparam logic [SYM_W-1:0] SYM_YUAN  = 5'd15;
    localparam logic [SYM_W-1:0] SYM_JIAO  = 5'd16;
    localparam logic [SYM_W-1:0] SYM_FEN   = 5'd17;
    localparam logic [SYM_W-1:0] SYM_ZHENG = 5'd18;

    // add three to every bcd digit of five or more (one double-dabble step)
    function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] v);
        logic [BCD_W-1:0] r;
        r = v;
        for (int i = 0; i < DIGITS; i++) begin
            if (v[4*i +: 4] >= 4'd5) begin
                r[4*i +: 4] = v[4*i +: 4] + 4'd3;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/amount_to_chinese_capital_symbols.sv
// sequence: an idle step, then shift-add bcd conversion (one bit a cycle
// through the shared adjust-and-shift unit), then the sequencer steps, one
// candidate symbol a step; a step with a symbol waits while the output stalls
// in_stall stays high from the accepting edge until the final symbol is loaded
// reset (rst_n low, asynchronous) returns to idle with no symbol pending
// depends on accs_pkg
`default_nettype none

module amount_to_chinese_capital_symbols (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [accs_pkg::AMT_W-1:0]  amount_fen,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [accs_pkg::SYM_W-1:0]       symbol,
    output logic                             last
);

    // sequencer: conversion, then one step per candidate symbol
    typedef enum logic [3:0] {
        S_IDLE,
        S_CONV,
        S_DIG,     // digit of current group, or ling, or nothing
        S_PUNIT,   // shi / bai / qian after a nonzero digit
        S_GUNIT,   // wan / yi after a nonzero upper group
        S_YUAN,
        S_JIAO,
        S_JSYM,
        S_FEN,
        S_FSYM,
        S_ZHENG
    } state_t;

    state_t                          state_reg, state_next;
    logic [accs_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [accs_pkg::AMT_W-1:0]      bin_reg, bin_next;
    logic [accs_pkg::BCD_W-1:0]      bcd_reg, bcd_next;
    logic [accs_pkg::BCD_W-1:0]      bcd_adj;
    logic [1:0]                      gi_reg, gi_next;     // group: 2 yi, 1 wan, 0 units
    logic [1:0]                      pos_reg, pos_next;   // digit place in the group
    logic                            out_valid_reg, out_valid_next;
    logic [accs_pkg::SYM_W-1:0]      symbol_reg, symbol_next;
    logic                            last_reg, last_next;

    // decoded view of the converted amount
    logic [3:0]  fen_d, jiao_d;
    logic [15:0] grp0, grp1, grp2, grp_cur;
    logic        grp0_nz, grp1_nz, grp2_nz, int_nz, frac_zero, all_zero;
    logic [3:0]  dig, d3, d2, d1, d0;
    logic        higher_nz, zero_ling;

    // candidate symbol of the current step
    logic                            cand_valid, cand_last, slot_free, advance;
    logic [accs_pkg::SYM_W-1:0]      cand_sym;

    // shared adjust unit of the double-dabble loop
    assign bcd_adj = accs_pkg::bcd_adjust(bcd_reg);

    assign fen_d     = bcd_reg[3:0];
    assign jiao_d    = bcd_reg[7:4];
    assign grp0      = bcd_reg[23:8];
    assign grp1      = bcd_reg[39:24];
    assign grp2      = {8'd0, bcd_reg[47:40]};
    assign grp0_nz   = |grp0;
    assign grp1_nz   = |grp1;
    assign grp2_nz   = |grp2;
    assign int_nz    = grp0_nz | grp1_nz | grp2_nz;
    assign frac_zero = (fen_d == 4'd0) && (jiao_d == 4'd0);
    assign all_zero  = !int_nz && frac_zero;

    always_comb
    begin
        case (gi_reg)
            2'd0:    grp_cur = grp0;
            2'd1:    grp_cur = grp1;
            2'd2:    grp_cur = grp2;
            default: grp_cur = 16'd0;
        endcase
    end

    assign d0  = grp_cur[3:0];
    assign d1  = grp_cur[7:4];
    assign d2  = grp_cur[11:8];
    assign d3  = grp_cur[15:12];
    assign dig = grp_cur[4*pos_reg +: 4];

    always_comb
    begin
        case (gi_reg)
            2'd0:    higher_nz = grp2_nz | grp1_nz;
            2'd1:    higher_nz = grp2_nz;
            default: higher_nz = 1'b0;
        endcase
    end

    // when a zero digit is spelled as ling
    always_comb
    begin
        case (pos_reg)
            2'd3:    zero_ling = higher_nz && ((d2 | d1 | d0) != 4'd0);
            2'd2:    zero_ling = (d3 != 4'd0) && ((d1 != 4'd0) || (d0 != 4'd0));
            2'd1:    zero_ling = (d2 != 4'd0) && (d0 != 4'd0);
            default: zero_ling = all_zero && (gi_reg == 2'd0);
        endcase
    end

    // candidate for this step; fen symbol or zheng closes the amount
    always_comb
    begin
        cand_valid = 1'b0;
        cand_sym   = accs_pkg::SYM_LING;
        cand_last  = 1'b0;
        unique case (state_reg)
            S_DIG:
            begin
                if (dig != 4'd0) begin
                    cand_valid = 1'b1;
                    cand_sym   = {1'b0, dig};
                end else if (zero_ling) begin
                    cand_valid = 1'b1;
                    cand_sym   = accs_pkg::SYM_LING;
                end
            end
            S_PUNIT:
            begin
                cand_valid = 1'b1;
                cand_sym   = accs_pkg::SYM_SHI + {3'd0, pos_reg - 2'd1};
            end
            S_GUNIT:
            begin
                cand_valid = (grp_cur != 16'd0) && (gi_reg != 2'd0);
                cand_sym   = (gi_reg == 2'd1) ? accs_pkg::SYM_WAN : accs_pkg::SYM_YI;
            end
            S_YUAN:
            begin
                cand_valid = int_nz || frac_zero;
                cand_sym   = accs_pkg::SYM_YUAN;
            end
            S_JIAO:
            begin
                // zero jiao gives ling only between a yuan part and a fen digit
                if (jiao_d != 4'd0) begin
                    cand_valid = 1'b1;
                    cand_sym   = {1'b0, jiao_d};
                end else if ((fen_d != 4'd0) && int_nz) begin
                    cand_valid = 1'b1;
                    cand_sym   = accs_pkg::SYM_LING;
                end
            end
            S_JSYM:
            begin
                cand_valid = (jiao_d != 4'd0);
                cand_sym   = accs_pkg::SYM_JIAO;
            end
            S_FEN:
            begin
                cand_valid = (fen_d != 4'd0);
                cand_sym   = {1'b0, fen_d};
            end
            S_FSYM:
            begin
                cand_valid = (fen_d != 4'd0);
                cand_sym   = accs_pkg::SYM_FEN;
                cand_last  = 1'b1;
            end
            S_ZHENG:
            begin
                cand_valid = 1'b1;
                cand_sym   = accs_pkg::SYM_ZHENG;
                cand_last  = 1'b1;
            end
            default:
            begin
                cand_valid = 1'b0;
            end
        endcase
    end

    // a step with a symbol waits for the output register to free up
    assign slot_free = !out_valid_reg || !out_stall;
    assign advance   = !cand_valid || slot_free;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        gi_next        = gi_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && out_stall;
        symbol_next    = symbol_reg;
        last_next      = last_reg;

        if (cand_valid && slot_free) begin
            out_valid_next = 1'b1;
            symbol_next    = cand_sym;
            last_next      = cand_last;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid) begin
                    // saturate above range, then start conversion
                    bin_next   = (amount_fen > accs_pkg::AMT_MAX) ? accs_pkg::AMT_MAX
                                                                  : amount_fen;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                bcd_next = {bcd_adj[accs_pkg::BCD_W-2:0], bin_reg[accs_pkg::AMT_W-1]};
                bin_next = {bin_reg[accs_pkg::AMT_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == accs_pkg::CNT_W'(accs_pkg::CONV_STEPS - 1)) begin
                    gi_next    = 2'd2;
                    pos_next   = 2'd3;
                    state_next = S_DIG;
                end
            end
            S_DIG:
            begin
                if (advance) begin
                    if ((dig != 4'd0) && (pos_reg != 2'd0)) begin
                        state_next = S_PUNIT;
                    end else if (pos_reg == 2'd0) begin
                        state_next = S_GUNIT;
                    end else begin
                        pos_next = pos_reg - 2'd1;
                    end
                end
            end
            S_PUNIT:
            begin
                if (advance) begin
                    pos_next   = pos_reg - 2'd1;
                    state_next = S_DIG;
                end
            end
            S_GUNIT:
            begin
                if (advance) begin
                    if (gi_reg == 2'd0) begin
                        state_next = S_YUAN;
                    end else begin
                        gi_next    = gi_reg - 2'd1;
                        pos_next   = 2'd3;
                        state_next = S_DIG;
                    end
                end
            end
            S_YUAN:  if (advance) state_next = S_JIAO;
            S_JIAO:  if (advance) state_next = S_JSYM;
            S_JSYM:  if (advance) state_next = S_FEN;
            S_FEN:   if (advance) state_next = S_FSYM;
            S_FSYM:
            begin
                if (advance) begin
                    state_next = (fen_d != 4'd0) ? S_IDLE : S_ZHENG;
                end
            end
            S_ZHENG: if (advance) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            bin_reg       <= '0;
            bcd_reg       <= '0;
            gi_reg        <= 2'd0;
            pos_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
            symbol_reg    <= accs_pkg::SYM_LING;
            last_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            bin_reg       <= bin_next;
            bcd_reg       <= bcd_next;
            gi_reg        <= gi_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            symbol_reg    <= symbol_next;
            last_reg      <= last_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign symbol    = symbol_reg;
    assign last      = last_reg;

    // an accepted amount always starts conversion
    a_start_conv: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_CONV)
        else $error("accepted amount did not start conversion");

    // conversion only leaves toward the digit walk
    a_conv_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CONV |=> state_reg == S_CONV || state_reg == S_DIG)
        else $error("conversion left to an unexpected step");

    // the closing symbol is fen or zheng
    a_last_sym: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |->
            (symbol_reg == accs_pkg::SYM_FEN || symbol_reg == accs_pkg::SYM_ZHENG))
        else $error("last flag on a symbol that cannot close an amount");

    // a symbol still pending while idle is the closing one
    a_idle_pending_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE && out_valid_reg |-> last_reg)
        else $error("non-final symbol pending after the sequence ended");

    // symbol codes stay within the defined set
    a_sym_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> symbol_reg <= accs_pkg::SYM_ZHENG)
        else $error("symbol code out of range");

endmodule

`default_nettype wire
